>>> sv/qgi_pkg.sv
package qgi_pkg;

  // component format: signed COMP_W bits, Q1.(COMP_W-2)
  localparam int COMP_W   = 16;
  localparam int FRAC     = COMP_W - 2;
  localparam int RATE_W   = 16;
  localparam int RATE_FRAC = 9;
  localparam int DT_W     = 16;
  localparam int DT_SHIFT = 21;
  localparam logic [DT_W-1:0] PERIOD_RESET = 16'd1049;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
  } qgi_in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] quat_w;
    logic signed [COMP_W-1:0] quat_x;
    logic signed [COMP_W-1:0] quat_y;
    logic signed [COMP_W-1:0] quat_z;
    logic                     fell_back;
  } qgi_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QMUL,
    ST_QACC,
    ST_DMUL,
    ST_DACC,
    ST_SQMUL,
    ST_SQACC,
    ST_CHECK,
    ST_SQRT,
    ST_DIVINIT,
    ST_DIV,
    ST_DIVEND,
    ST_OUT
  } qgi_state_t;

  // hamilton product q (x) (0, g): orientation term index per component and term
  function automatic logic [1:0] qd_qidx(input logic [1:0] c, input logic [1:0] t);
    logic [1:0] r;
    unique case ({c, t})
      4'b00_00: r = 2'd1;
      4'b00_01: r = 2'd2;
      4'b00_10: r = 2'd3;
      4'b01_00: r = 2'd0;
      4'b01_01: r = 2'd2;
      4'b01_10: r = 2'd3;
      4'b10_00: r = 2'd0;
      4'b10_01: r = 2'd1;
      4'b10_10: r = 2'd3;
      4'b11_00: r = 2'd0;
      4'b11_01: r = 2'd1;
      4'b11_10: r = 2'd2;
      default:  r = 2'd0;
    endcase
    return r;
  endfunction

  // rate index per component and term
  function automatic logic [1:0] qd_gidx(input logic [1:0] c, input logic [1:0] t);
    logic [1:0] r;
    unique case ({c, t})
      4'b00_00: r = 2'd0;
      4'b00_01: r = 2'd1;
      4'b00_10: r = 2'd2;
      4'b01_00: r = 2'd0;
      4'b01_01: r = 2'd2;
      4'b01_10: r = 2'd1;
      4'b10_00: r = 2'd1;
      4'b10_01: r = 2'd2;
      4'b10_10: r = 2'd0;
      4'b11_00: r = 2'd2;
      4'b11_01: r = 2'd1;
      4'b11_10: r = 2'd0;
      default:  r = 2'd0;
    endcase
    return r;
  endfunction

  // term is subtracted
  function automatic logic qd_neg(input logic [1:0] c, input logic [1:0] t);
    logic r;
    unique case ({c, t})
      4'b00_00, 4'b00_01, 4'b00_10: r = 1'b1;
      4'b01_10, 4'b10_01, 4'b11_10: r = 1'b1;
      default:                      r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/quaternion_gyro_integrator.sv
// First-order gyro integrator: holds an orientation quaternion (identity after reset),
// and for each item of three body rates (Q6.9 rad/s) adds 0.5*q(x)(0,w)*dt, saturates,
// then renormalizes through an integer square root and four divisions. A near-zero
// norm restores the identity and sets fell_back. cfg_wdata sets dt in 2^-20 s and is to be
// written by the user only while idle; the block itself does not enforce this. Each item
// makes 20 passes through the one shared multiplier, then runs a square root that settles
// one root bit per cycle and a restoring divider that settles one quotient bit per cycle
// for each component, with a setup step before and a write-back step after each division.
// in_ready is high only between items; a finished result waits in the output register
// while the next item is taken.
module quaternion_gyro_integrator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  qgi_pkg::qgi_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output qgi_pkg::qgi_out_t   out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);
  import qgi_pkg::*;

  localparam int AW    = COMP_W + 12;           // multiplier a operand
  localparam int BW    = (COMP_W > DT_W + 1) ? COMP_W : DT_W + 1;
  localparam int PW    = AW + BW;
  localparam int ACW   = COMP_W + RATE_W + 2;   // qdot accumulator
  localparam int NW    = 2 * COMP_W + 1;        // squared norm
  localparam int SW    = 2 * COMP_W + 2;        // sqrt shift register
  localparam int RTW   = COMP_W + 1;            // root
  localparam int RMW   = COMP_W + 4;            // sqrt remainder
  localparam int SQ_IT = COMP_W + 1;
  localparam int DV_IT = FRAC + 1;
  localparam int DW    = COMP_W + FRAC + 3;
  localparam int DRW   = COMP_W + 4;
  localparam int ITW   = $clog2(SQ_IT + 1);
  localparam longint unsigned THRESH =
    ((64'd1 << (2 * FRAC)) + 64'd999999999999) / 64'd1000000000000;
  localparam logic signed [COMP_W-1:0] ONE  = COMP_W'(1) << FRAC;
  localparam logic signed [COMP_W-1:0] CMAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic signed [COMP_W-1:0] CMIN = {1'b1, {(COMP_W-1){1'b0}}};

  qgi_state_t state_r, state_nxt;

  logic [DT_W-1:0]          dt_r;
  logic signed [COMP_W-1:0] q_r  [4];
  logic signed [COMP_W-1:0] nv_r [4];
  logic signed [RATE_W-1:0] g_r  [3];
  logic [1:0]               c_r;
  logic [1:0]               t_r;
  logic [ITW-1:0]           it_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [ACW-1:0]    acc_r;
  logic [NW-1:0]            norm_r;
  logic [SW-1:0]            sn_r;
  logic [RMW-1:0]           rem_r;
  logic [RTW-1:0]           root_r;
  logic [DRW-1:0]           drem_r;
  logic [FRAC:0]            dlow_r;
  logic [FRAC:0]            dq_r;
  logic                     dneg_r;
  logic                     fell_r;
  logic                     out_valid_r;
  qgi_out_t                 out_r;

  // control decoded from state
  logic                     take_item;
  logic                     load_out;
  logic                     last_term;
  logic                     last_comp;
  logic                     sqrt_done;
  logic                     div_done;
  logic                     small_norm;

  // shared multiplier operands
  logic signed [AW-1:0]     mul_a;
  logic signed [BW-1:0]     mul_b;
  logic signed [ACW-1:0]    rnd_acc;
  logic signed [PW-1:0]     dsum;
  logic signed [PW-1:0]     csum;
  logic signed [COMP_W-1:0] csat;
  logic [1:0]               qi;
  logic [1:0]               gi;
  logic [RMW-1:0]           sq_try;
  logic [RMW-1:0]           sq_rem;
  logic [DW-1:0]            dnum;
  logic [COMP_W-1:0]        mag;
  logic [DRW-1:0]           dtry;
  logic [DRW-1:0]           ddiv;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_QMUL;
      ST_QMUL:    state_nxt = ST_QACC;
      ST_QACC:    state_nxt = last_term ? ST_DMUL : ST_QMUL;
      ST_DMUL:    state_nxt = ST_DACC;
      ST_DACC:    state_nxt = ST_SQMUL;
      ST_SQMUL:   state_nxt = ST_SQACC;
      ST_SQACC:   state_nxt = last_comp ? ST_CHECK : ST_QMUL;
      ST_CHECK:   state_nxt = small_norm ? ST_OUT : ST_SQRT;
      ST_SQRT:    if (sqrt_done) state_nxt = ST_DIVINIT;
      ST_DIVINIT: state_nxt = ST_DIV;
      ST_DIV:     if (div_done) state_nxt = ST_DIVEND;
      ST_DIVEND:  state_nxt = last_comp ? ST_OUT : ST_DIVINIT;
      ST_OUT:     if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    take_item  = in_valid && (state_r == ST_IDLE);
    load_out   = (state_r == ST_OUT) && (!out_valid_r || out_ready);
    last_term  = (t_r == 2'd2);
    last_comp  = (c_r == 2'd3);
    sqrt_done  = (it_r == ITW'(SQ_IT - 1));
    div_done   = (it_r == ITW'(DV_IT - 1));
    small_norm = (norm_r < NW'(THRESH));
  end

  // operand select for the shared multiplier
  always_comb begin
    qi      = qd_qidx(c_r, t_r);
    gi      = qd_gidx(c_r, t_r);
    rnd_acc = (acc_r + ACW'(1 << (RATE_FRAC - 1))) >>> RATE_FRAC;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_r)
      ST_QMUL: begin
        mul_a = AW'(q_r[qi]);
        mul_b = BW'(g_r[gi]);
      end
      ST_DMUL: begin
        mul_a = AW'(rnd_acc);
        mul_b = BW'(signed'({1'b0, dt_r}));
      end
      ST_SQMUL: begin
        mul_a = AW'(nv_r[c_r]);
        mul_b = BW'(nv_r[c_r]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // increment, sum and saturation
  always_comb begin
    dsum = (prod_r + PW'(1 << (DT_SHIFT - 1))) >>> DT_SHIFT;
    csum = PW'(q_r[c_r]) + dsum;
    if (csum > PW'(CMAX)) csat = CMAX;
    else if (csum < PW'(CMIN)) csat = CMIN;
    else csat = csum[COMP_W-1:0];
  end

  // square root and divider steps
  always_comb begin
    sq_rem = {rem_r[RMW-3:0], sn_r[SW-1:SW-2]};
    sq_try = RMW'({root_r, 2'b01});
    mag    = nv_r[c_r][COMP_W-1] ? COMP_W'(-nv_r[c_r]) : COMP_W'(nv_r[c_r]);
    dnum   = (DW'(mag) << (FRAC + 1)) + DW'(root_r);
    dtry   = {drem_r[DRW-2:0], dlow_r[FRAC]};
    ddiv   = DRW'({root_r, 1'b0});
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cfg_we) dt_r <= cfg_wdata;
    prod_r <= PW'(mul_a * mul_b);
    unique case (state_r)
      ST_IDLE: begin
        c_r <= 2'd0;
        t_r <= 2'd0;
        if (take_item) begin
          g_r[0] <= in_data.rate_x;
          g_r[1] <= in_data.rate_y;
          g_r[2] <= in_data.rate_z;
          norm_r <= '0;
        end
      end
      ST_QACC: begin
        if (t_r == 2'd0)
          acc_r <= qd_neg(c_r, t_r) ? -ACW'(prod_r) : ACW'(prod_r);
        else
          acc_r <= qd_neg(c_r, t_r) ? acc_r - ACW'(prod_r) : acc_r + ACW'(prod_r);
        t_r <= last_term ? 2'd0 : t_r + 2'd1;
      end
      ST_DACC: nv_r[c_r] <= csat;
      ST_SQACC: begin
        norm_r <= norm_r + NW'(prod_r[2*COMP_W-1:0]);
        c_r    <= c_r + 2'd1;
      end
      ST_CHECK: begin
        sn_r   <= SW'(norm_r);
        rem_r  <= '0;
        root_r <= '0;
        it_r   <= '0;
        fell_r <= small_norm;
        if (small_norm) begin
          q_r[0] <= ONE;
          q_r[1] <= '0;
          q_r[2] <= '0;
          q_r[3] <= '0;
        end
      end
      ST_SQRT: begin
        sn_r <= sn_r << 2;
        it_r <= it_r + ITW'(1);
        if (sq_rem >= sq_try) begin
          rem_r  <= sq_rem - sq_try;
          root_r <= {root_r[RTW-2:0], 1'b1};
        end else begin
          rem_r  <= sq_rem;
          root_r <= {root_r[RTW-2:0], 1'b0};
        end
      end
      ST_DIVINIT: begin
        drem_r <= DRW'(dnum >> (FRAC + 1));
        dlow_r <= dnum[FRAC:0];
        dneg_r <= nv_r[c_r][COMP_W-1];
        dq_r   <= '0;
        it_r   <= '0;
      end
      ST_DIV: begin
        dlow_r <= dlow_r << 1;
        it_r   <= it_r + ITW'(1);
        if (dtry >= ddiv) begin
          drem_r <= dtry - ddiv;
          dq_r   <= {dq_r[FRAC-1:0], 1'b1};
        end else begin
          drem_r <= dtry;
          dq_r   <= {dq_r[FRAC-1:0], 1'b0};
        end
      end
      ST_DIVEND: begin
        q_r[c_r] <= dneg_r ? -COMP_W'(dq_r) : COMP_W'(dq_r);
        c_r      <= c_r + 2'd1;
      end
      default: ;
    endcase
    if (load_out) begin
      out_r.quat_w    <= q_r[0];
      out_r.quat_x    <= q_r[1];
      out_r.quat_y    <= q_r[2];
      out_r.quat_z    <= q_r[3];
      out_r.fell_back <= fell_r;
    end
    if (!rst_n) begin
      dt_r   <= PERIOD_RESET;
      q_r[0] <= ONE;
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // a fallback result is the identity
  a_fell_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.fell_back |->
      out_r.quat_w == ONE && out_r.quat_x == '0 && out_r.quat_y == '0 && out_r.quat_z == '0)
    else $error("fallback result is not the identity");

  // an accepted item starts the sequencer
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_QMUL)
    else $error("accepted item did not start");

  // normalized w and x components stay within one
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.quat_w <= ONE && out_r.quat_w >= -ONE &&
                    out_r.quat_x <= ONE && out_r.quat_x >= -ONE)
    else $error("component beyond unit range");
`endif

endmodule
